// File: hw/rtl/utt_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// utt_pkg
// Shared types, codes and helpers for the UTF-16/UTF-32 to UTF-8 transcoder.
// ============================================================================
package utt_pkg;

    // Decoding mode chosen once per stream.
    typedef enum logic [2:0] {
        MODE_UTF8  = 3'd0,
        MODE_U16LE = 3'd1,
        MODE_U16BE = 3'd2,
        MODE_U32LE = 3'd3,
        MODE_U32BE = 3'd4
    } mode_t;

    // Codes of the encoding register.
    typedef enum logic [2:0] {
        REQ_AUTO    = 3'd0,
        REQ_UTF8    = 3'd1,
        REQ_UTF16   = 3'd2,
        REQ_UTF16LE = 3'd3,
        REQ_UTF16BE = 3'd4,
        REQ_UTF32   = 3'd5,
        REQ_UTF32LE = 3'd6,
        REQ_UTF32BE = 3'd7
    } req_enc_t;

    // Slots of one burst: first unit (two emits), second unit (two emits),
    // and the end-of-stream flush of a dangling high surrogate.
    localparam int NumSlots  = 5;
    localparam int SlotFlush = 4;

    localparam logic [20:0] CpReplacement = 21'h00FFFD;
    localparam logic [31:0] CpMax         = 32'h0010FFFF;
    localparam logic [20:0] CpSuppBase    = 21'h010000;

    // One output symbol: a raw byte (UTF-8 pass-through) or a code point.
    typedef struct packed {
        logic        raw;
        logic [20:0] value;
    } sym_t;

    // Everything one input byte produces, handed to the output stage.
    typedef struct packed {
        logic [NumSlots-1:0] mask;
        sym_t [NumSlots-1:0] sym;
    } burst_t;

    typedef struct packed {
        logic        vld;
        logic [20:0] cp;
    } emit_t;

    typedef struct packed {
        emit_t       e1;
        emit_t       e2;
        logic        pv;
        logic [15:0] ph;
    } take16_t;

    // Drops code point zero and replaces surrogates and out-of-range values.
    function automatic emit_t make_cp(input logic [31:0] cp);
        emit_t e;
        e.vld = (cp != 32'h0);
        if (cp > CpMax || (cp inside {[32'h0000D800:32'h0000DFFF]})) begin
            e.cp = CpReplacement;
        end else begin
            e.cp = cp[20:0];
        end
        return e;
    endfunction

    function automatic logic is_high(input logic [15:0] w);
        return (w inside {[16'hD800:16'hDBFF]});
    endfunction

    function automatic logic is_low(input logic [15:0] w);
        return (w inside {[16'hDC00:16'hDFFF]});
    endfunction

    // One UTF-16 code unit against the pending high surrogate. e1 carries
    // the joined pair or the replacement for a broken pair, e2 the unit's
    // own code point.
    function automatic take16_t take_unit16(input logic pv, input logic [15:0] ph,
                                            input logic [15:0] w);
        take16_t r;
        logic    own;
        r    = '0;
        own  = 1'b1;
        r.pv = pv;
        r.ph = ph;
        if (pv) begin
            r.pv = 1'b0;
            r.ph = '0;
            r.e1.vld = 1'b1;
            if (is_low(w)) begin
                r.e1.cp = CpSuppBase + {1'b0, ph[9:0], w[9:0]};
                own     = 1'b0;
            end else begin
                r.e1.cp = CpReplacement;
            end
        end
        if (own) begin
            if (is_high(w)) begin
                r.pv = 1'b1;
                r.ph = w;
            end else if (is_low(w)) begin
                r.e2.vld = 1'b1;
                r.e2.cp  = CpReplacement;
            end else begin
                r.e2 = make_cp({16'h0000, w});
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/utt_core.sv
`timescale 1ns / 1ps
// ============================================================================
// utt_core
// Stream state, byte order mark detection and code unit assembly. Turns one
// registered input byte combinationally into a burst of output symbols.
// ============================================================================
module utt_core
    import utt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       fire,
    input  logic [7:0] in_byte,
    input  logic       in_fin,
    input  logic       cfg_we,
    input  logic [2:0] cfg_data,
    output burst_t     burst
);

    req_enc_t    req_reg;
    logic [23:0] head_reg, head_next;
    logic [1:0]  hcnt_reg, hcnt_next;
    logic        decided_reg, decided_next;
    mode_t       mode_reg, mode_next;
    logic [23:0] acc_reg, acc_next;
    logic [1:0]  ucnt_reg, ucnt_next;
    logic [15:0] ph_reg, ph_next;
    logic        pv_reg, pv_next;

    logic [31:0] held;
    logic [7:0]  b0, b1, b2, b3;
    logic [2:0]  n;
    logic        do_decide;
    logic        bom_found;
    mode_t       bom_mode;
    logic [2:0]  skip;
    mode_t       dmode;
    logic [2:0]  start;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_reg <= REQ_AUTO;
        end else if (cfg_we) begin
            req_reg <= req_enc_t'(cfg_data);
        end
    end

    // Held bytes with the incoming byte placed behind them.
    always_comb begin
        held = {8'h00, head_reg};
        held[8*hcnt_reg +: 8] = in_byte;
        b0 = held[7:0];
        b1 = held[15:8];
        b2 = held[23:16];
        b3 = held[31:24];
        n  = {1'b0, hcnt_reg} + 3'd1;
        do_decide = !decided_reg && ((n == 3'd4) || in_fin);
    end

    // Mark detection, tested in priority order.
    always_comb begin
        bom_found = 1'b1;
        bom_mode  = MODE_UTF8;
        skip      = 3'd0;
        if (n == 3'd4 && b0 == 8'hFF && b1 == 8'hFE && b2 == 8'h00 && b3 == 8'h00) begin
            bom_mode = MODE_U32LE;
            skip     = 3'd4;
        end else if (n == 3'd4 && b0 == 8'h00 && b1 == 8'h00 && b2 == 8'hFE
                     && b3 == 8'hFF) begin
            bom_mode = MODE_U32BE;
            skip     = 3'd4;
        end else if (n >= 3'd3 && b0 == 8'hEF && b1 == 8'hBB && b2 == 8'hBF) begin
            bom_mode = MODE_UTF8;
            skip     = 3'd3;
        end else if (n >= 3'd2 && b0 == 8'hFF && b1 == 8'hFE) begin
            bom_mode = MODE_U16LE;
            skip     = 3'd2;
        end else if (n >= 3'd2 && b0 == 8'hFE && b1 == 8'hFF) begin
            bom_mode = MODE_U16BE;
            skip     = 3'd2;
        end else begin
            bom_found = 1'b0;
        end
    end

    // Mark weighed against the requested encoding.
    always_comb begin
        start = 3'd0;
        case (req_reg)
            REQ_AUTO: begin
                if (bom_found) begin
                    dmode = bom_mode;
                    start = skip;
                end else begin
                    dmode = MODE_UTF8;
                end
            end
            REQ_UTF8:    dmode = MODE_UTF8;
            REQ_UTF16: begin
                if (bom_found && (bom_mode == MODE_U16LE || bom_mode == MODE_U16BE)) begin
                    dmode = bom_mode;
                    start = skip;
                end else begin
                    dmode = MODE_U16LE;
                end
            end
            REQ_UTF16LE: dmode = MODE_U16LE;
            REQ_UTF16BE: dmode = MODE_U16BE;
            REQ_UTF32: begin
                if (bom_found && (bom_mode == MODE_U32LE || bom_mode == MODE_U32BE)) begin
                    dmode = bom_mode;
                    start = skip;
                end else begin
                    dmode = MODE_U32LE;
                end
            end
            REQ_UTF32LE: dmode = MODE_U32LE;
            default:     dmode = MODE_U32BE;
        endcase
        if ((req_reg inside {REQ_UTF8, REQ_UTF16LE, REQ_UTF16BE, REQ_UTF32LE, REQ_UTF32BE})
            && bom_found && bom_mode == dmode) begin
            start = skip;
        end
    end

    // Unit assembly, surrogate handling and the burst.
    always_comb begin
        mode_t       mode_use;
        logic        le, u16;
        logic        unit_a_vld, unit_b_vld;
        logic [31:0] unit_a;
        logic [15:0] unit_b;
        logic        pv_t;
        logic [15:0] ph_t;
        take16_t     t;
        emit_t       e;

        head_next    = head_reg;
        hcnt_next    = hcnt_reg;
        decided_next = decided_reg;
        mode_next    = mode_reg;
        acc_next     = acc_reg;
        ucnt_next    = ucnt_reg;
        burst        = '0;
        unit_a_vld   = 1'b0;
        unit_b_vld   = 1'b0;
        unit_a       = '0;
        unit_b       = '0;
        pv_t         = pv_reg;
        ph_t         = ph_reg;
        t            = '0;
        e            = '0;

        mode_use = do_decide ? dmode : mode_reg;
        le  = (mode_use inside {MODE_U16LE, MODE_U32LE});
        u16 = (mode_use inside {MODE_U16LE, MODE_U16BE});

        if (decided_reg) begin
            case (mode_reg)
                MODE_UTF8: begin
                    burst.mask[0] = 1'b1;
                    burst.sym[0]  = {1'b1, 13'h0000, in_byte};
                end
                MODE_U16LE, MODE_U16BE: begin
                    if (ucnt_reg == 2'd1) begin
                        unit_a_vld = 1'b1;
                        unit_a = {16'h0000, le ? {in_byte, acc_reg[7:0]}
                                               : {acc_reg[7:0], in_byte}};
                        acc_next  = '0;
                        ucnt_next = 2'd0;
                    end else begin
                        acc_next  = {16'h0000, in_byte};
                        ucnt_next = 2'd1;
                    end
                end
                default: begin
                    if (ucnt_reg == 2'd3) begin
                        unit_a_vld = 1'b1;
                        unit_a    = le ? {in_byte, acc_reg} : {acc_reg, in_byte};
                        acc_next  = '0;
                        ucnt_next = 2'd0;
                    end else begin
                        if (le) begin
                            acc_next[8*ucnt_reg +: 8] = in_byte;
                        end else begin
                            acc_next = {acc_reg[15:0], in_byte};
                        end
                        ucnt_next = ucnt_reg + 2'd1;
                    end
                end
            endcase
        end else if (do_decide) begin
            decided_next = 1'b1;
            mode_next    = dmode;
            case (dmode)
                MODE_UTF8: begin
                    for (int k = 0; k < 4; k++) begin
                        if (3'(k) >= start && 3'(k) < n) begin
                            burst.mask[k] = 1'b1;
                            burst.sym[k]  = {1'b1, 13'h0000, held[8*k +: 8]};
                        end
                    end
                end
                MODE_U16LE, MODE_U16BE: begin
                    if (start == 3'd0 && n >= 3'd2) begin
                        unit_a_vld = 1'b1;
                        unit_a = {16'h0000, le ? {b1, b0} : {b0, b1}};
                    end else if (start == 3'd2 && n == 3'd4) begin
                        unit_a_vld = 1'b1;
                        unit_a = {16'h0000, le ? {b3, b2} : {b2, b3}};
                    end
                    if (start == 3'd0 && n == 3'd4) begin
                        unit_b_vld = 1'b1;
                        unit_b = le ? {b3, b2} : {b2, b3};
                    end
                end
                default: begin
                    if (start == 3'd0 && n == 3'd4) begin
                        unit_a_vld = 1'b1;
                        unit_a = le ? held : {b0, b1, b2, b3};
                    end
                end
            endcase
            // A trailing partial unit here only happens at the end of the
            // stream, where it is dropped, so the accumulator stays clear.
        end else begin
            head_next = held[23:0];
            hcnt_next = hcnt_reg + 2'd1;
        end

        if (unit_a_vld) begin
            if (u16) begin
                t = take_unit16(pv_t, ph_t, unit_a[15:0]);
                burst.mask[0] = t.e1.vld;
                burst.sym[0]  = {1'b0, t.e1.cp};
                burst.mask[1] = t.e2.vld;
                burst.sym[1]  = {1'b0, t.e2.cp};
                pv_t = t.pv;
                ph_t = t.ph;
            end else begin
                e = make_cp(unit_a);
                burst.mask[1] = e.vld;
                burst.sym[1]  = {1'b0, e.cp};
            end
        end
        if (unit_b_vld) begin
            t = take_unit16(pv_t, ph_t, unit_b);
            burst.mask[2] = t.e1.vld;
            burst.sym[2]  = {1'b0, t.e1.cp};
            burst.mask[3] = t.e2.vld;
            burst.sym[3]  = {1'b0, t.e2.cp};
            pv_t = t.pv;
            ph_t = t.ph;
        end

        pv_next = pv_t;
        ph_next = ph_t;

        // End of stream: flush a dangling high surrogate, then start fresh.
        if (in_fin) begin
            if (pv_t) begin
                burst.mask[SlotFlush] = 1'b1;
                burst.sym[SlotFlush]  = {1'b0, CpReplacement};
            end
            head_next    = '0;
            hcnt_next    = '0;
            decided_next = 1'b0;
            mode_next    = MODE_UTF8;
            acc_next     = '0;
            ucnt_next    = '0;
            pv_next      = 1'b0;
            ph_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            hcnt_reg    <= '0;
            decided_reg <= 1'b0;
            mode_reg    <= MODE_UTF8;
            acc_reg     <= '0;
            ucnt_reg    <= '0;
            ph_reg      <= '0;
            pv_reg      <= 1'b0;
        end else if (fire) begin
            head_reg    <= head_next;
            hcnt_reg    <= hcnt_next;
            decided_reg <= decided_next;
            mode_reg    <= mode_next;
            acc_reg     <= acc_next;
            ucnt_reg    <= ucnt_next;
            ph_reg      <= ph_next;
            pv_reg      <= pv_next;
        end
    end

endmodule

// File: hw/rtl/utt_serializer.sv
`timescale 1ns / 1ps
// ============================================================================
// utt_serializer
// Result register for one burst; sends UTF-8, a byte a cycle unless stalled.
// ============================================================================
module utt_serializer
    import utt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  burst_t     burst,
    output logic       load_ok,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_end
);

    logic [NumSlots-1:0] mask_reg;
    sym_t [NumSlots-1:0] sym_reg;
    logic [1:0]          idx_reg;

    logic [2:0]          sel;
    sym_t                cur;
    logic [1:0]          last_idx;
    logic [NumSlots-1:0] rest;
    logic                last_sym;

    // Lowest pending slot is the one on the wire.
    always_comb begin
        sel = '0;
        for (int i = NumSlots - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel = 3'(i);
            end
        end
        cur  = sym_reg[sel];
        rest = mask_reg;
        rest[sel] = 1'b0;
    end

    always_comb begin
        if (cur.raw || cur.value <= 21'h00007F) begin
            last_idx = 2'd0;
        end else if (cur.value <= 21'h0007FF) begin
            last_idx = 2'd1;
        end else if (cur.value <= 21'h00FFFF) begin
            last_idx = 2'd2;
        end else begin
            last_idx = 2'd3;
        end

        if (idx_reg == last_idx) begin
            m_out_byte = cur.raw ? cur.value[7:0] : {1'b0, cur.value[6:0]};
            if (last_idx != 2'd0) begin
                m_out_byte = {2'b10, cur.value[5:0]};
            end
        end else if (idx_reg == 2'd0) begin
            case (last_idx)
                2'd1:    m_out_byte = {3'b110, cur.value[10:6]};
                2'd2:    m_out_byte = {4'b1110, cur.value[15:12]};
                default: m_out_byte = {5'b11110, cur.value[20:18]};
            endcase
        end else if (idx_reg == 2'd1 && last_idx == 2'd3) begin
            m_out_byte = {2'b10, cur.value[17:12]};
        end else begin
            m_out_byte = {2'b10, cur.value[11:6]};
        end

        last_sym  = (idx_reg == last_idx);
        m_valid   = (mask_reg != '0);
        m_run_end = last_sym && (rest == '0);
        load_ok   = (mask_reg == '0) || (m_ready && m_run_end);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
            idx_reg  <= '0;
        end else if (load) begin
            mask_reg <= burst.mask;
            idx_reg  <= '0;
        end else if (m_valid && m_ready) begin
            if (last_sym) begin
                mask_reg <= rest;
                idx_reg  <= '0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sym_reg <= burst.sym;
        end
    end

endmodule

// File: hw/rtl/utf16_utf32_to_utf8_transcoder.sv
`timescale 1ns / 1ps
// ============================================================================
// utf16_utf32_to_utf8_transcoder
// Byte stream in UTF-8, UTF-16 or UTF-32 with optional byte order mark, out
// as UTF-8 bytes.
// ============================================================================
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_valid / s_ready    s_in_byte[7:0], s_final_byte
//  m_       out        m_valid / m_ready    m_out_byte[7:0], m_run_end
//  cfg_     in         cfg_valid/cfg_ready  cfg_encoding[2:0]
//
// An input register feeds a combinational decode into the result register;
// the first output byte is offered once the input byte has moved into it. A
// byte that gives several output bytes holds the input until the last one is
// taken; with at most one each, one byte per cycle goes through while m_ready
// is high. Reset (synchronous, active low) selects auto and clears all stream
// state; the configuration port is always ready.
//
// While the mode is undecided the first bytes of a stream (up to three, or
// fewer when the final byte comes early) are held and give no output; the
// byte that decides the mode releases the held bytes past the mark at once.
// The final byte flushes a pending high surrogate as U+FFFD, drops a partial
// code unit, and makes the next transfer start a new stream.
// ============================================================================
module utf16_utf32_to_utf8_transcoder
    import utt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_final_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_end,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_encoding
);

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_fin_reg;
    logic       load_ok;
    logic       fire;
    burst_t     burst;

    // The registered byte moves on when the result register can take its
    // whole burst; the input register refills in the same cycle.
    assign fire      = in_vld_reg && load_ok;
    assign s_ready   = !in_vld_reg || fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (fire) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
            in_fin_reg  <= s_final_byte;
        end
    end

    utt_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .in_byte  (in_byte_reg),
        .in_fin   (in_fin_reg),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_encoding),
        .burst    (burst)
    );

    utt_serializer u_serializer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (fire),
        .burst      (burst),
        .load_ok    (load_ok),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_run_end  (m_run_end)
    );

endmodule
